>>> src/wclc_pkg.sv
package wclc_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W    = 32;
    localparam int MIN_LEVEL_W = 31;
    localparam int LEN_CFG_W   = 11;
    localparam int LEVEL_W     = 4;

    // Products of a non-negative 31-bit value and a factor of at most 19.
    localparam int PROD_W = 36;

    // Number of grading steps (levels 1 to 9).
    localparam int GRADE_STEPS = 9;

    // Shortest series that the position counter honors.
    localparam int MIN_SERIES_LEN = 5;

    // Register reset values.
    localparam logic [LEN_CFG_W-1:0]   SERIES_LENGTH_RESET = 11'd1024;
    localparam logic [MIN_LEVEL_W-1:0] MIN_LEVEL_RESET     = 31'd1678;

    // Configuration register indexes.
    typedef enum logic {
        CFG_SERIES_LENGTH = 1'b0,
        CFG_MIN_LEVEL     = 1'b1
    } cfg_index_t;

    // Number of result words that one sample produces once it has results.
    typedef enum logic {
        RES_ONE = 1'b0,
        RES_TWO = 1'b1
    } res_count_t;

endpackage

>>> src/window_change_level_classifier.sv
// Window change level classifier.
//
// Samples (signed Q8.24) enter on the s_ channel, one word per sample. Each
// middle sample of a three-sample window is graded with a change level from
// 0 to 9, and the result leaves on the m_ channel with its position in the
// series. Sample k of a series yields the result for position k-1; the last
// sample of a series yields two words, the second one for its own position
// with m_tlast set. The first sample of a series yields nothing.
// The cfg channel writes series_length (index 0) and min_level (index 1); it
// is always ready and must only be used while no results are outstanding.
// Throughput: one sample per cycle while the queue has room; the grading is
// one stage of constant-ratio compares between the input register and a
// four-word result queue. The second word at the end of a series takes the
// slot that the silent first sample of the next series leaves free.
// When the receiver stalls, the queue fills and s_tready drops once fewer
// than two free words remain behind the word that waits in the input stage.
// Reset clears the registers to their defaults, the sample history to zero,
// the position counter to zero and empties both stages.
module window_change_level_classifier #(
    parameter int MAX_SERIES_LEN = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Sample input.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [wclc_pkg::SAMPLE_W-1:0]          s_tdata,   // [31:0] sample
    // Result output.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((wclc_pkg::LEVEL_W + $clog2(MAX_SERIES_LEN) + 7) / 8) * 8 - 1:0]
                                                   m_tdata,   // change_level, position, zero fill
    output logic                                   m_tlast,   // last_of_series
    // Configuration writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [wclc_pkg::MIN_LEVEL_W-1:0]       cfg_data
);

    localparam int POS_W   = $clog2(MAX_SERIES_LEN);
    localparam int LEN_W   = $clog2(MAX_SERIES_LEN + 1);
    localparam int CMP_W   = (LEN_W > wclc_pkg::LEN_CFG_W) ? LEN_W : wclc_pkg::LEN_CFG_W;
    localparam int OUT_W   = ((wclc_pkg::LEVEL_W + POS_W + 7) / 8) * 8;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int PAD_W   = OUT_W - wclc_pkg::LEVEL_W - POS_W;

    // Configuration registers.
    logic [wclc_pkg::LEN_CFG_W-1:0]   series_length_reg;
    logic [wclc_pkg::MIN_LEVEL_W-1:0] min_level_reg;

    // Sample history and position counter.
    logic [wclc_pkg::SAMPLE_W-1:0] older_reg, newer_reg;
    logic [POS_W-1:0]              pos_reg, pos_next;

    // Input stage: one accepted window waiting to be graded.
    logic                           s1_valid_reg, s1_valid_next;
    logic [wclc_pkg::SAMPLE_W-1:0]  s1_a_reg, s1_b_reg, s1_c_reg;
    logic [POS_W-1:0]               s1_pos_reg, s1_pos_next;
    logic                           s1_grade_reg, s1_grade_next;
    wclc_pkg::res_count_t           s1_count_reg, s1_count_next;
    logic                           s1_load;

    // Result queue.
    logic [wclc_pkg::LEVEL_W-1:0]   fifo_level_reg [FIFO_DEPTH];
    logic [POS_W-1:0]               fifo_pos_reg   [FIFO_DEPTH];
    logic                           fifo_last_reg  [FIFO_DEPTH];
    logic [PTR_W-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]               wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;

    logic s_accept, m_accept, s1_push;
    logic [CMP_W-1:0] eff_len, last_pos, pos_ext;
    logic is_final;
    logic [wclc_pkg::LEVEL_W-1:0] grade_level;

    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // The queue must have room for two words before the input stage moves on.
    assign s1_push  = s1_valid_reg && (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !s1_valid_reg || s1_push;

    // ------------------------------------------------------------------
    // Configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_length_reg <= wclc_pkg::SERIES_LENGTH_RESET;
            min_level_reg     <= wclc_pkg::MIN_LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wclc_pkg::cfg_index_t'(cfg_index))
                wclc_pkg::CFG_SERIES_LENGTH:
                    series_length_reg <= cfg_data[wclc_pkg::LEN_CFG_W-1:0];
                wclc_pkg::CFG_MIN_LEVEL:
                    min_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position tracking at the input.
    // ------------------------------------------------------------------
    always_comb
    begin
        eff_len = CMP_W'(series_length_reg);
        if (eff_len < CMP_W'(wclc_pkg::MIN_SERIES_LEN))
            eff_len = CMP_W'(wclc_pkg::MIN_SERIES_LEN);
        if (eff_len > CMP_W'(MAX_SERIES_LEN))
            eff_len = CMP_W'(MAX_SERIES_LEN);
        last_pos = eff_len - CMP_W'(1);
        pos_ext  = CMP_W'(pos_reg);
        is_final = (pos_ext >= last_pos);
    end

    always_comb
    begin
        s1_load       = 1'b0;
        pos_next      = pos_reg;
        s1_pos_next   = pos_reg - POS_W'(1);
        s1_grade_next = 1'b0;
        s1_count_next = wclc_pkg::RES_ONE;
        priority if (is_final)
        begin
            // Final sample: two level-zero words, the second one closing the series.
            s1_load       = 1'b1;
            s1_count_next = wclc_pkg::RES_TWO;
            pos_next      = '0;
        end
        else if (pos_reg == '0)
        begin
            // First sample of a series only fills the window.
            pos_next = POS_W'(1);
        end
        else
        begin
            s1_load       = 1'b1;
            s1_grade_next = (pos_reg >= POS_W'(3));
            pos_next      = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_push)
            s1_valid_next = 1'b0;
        if (s_accept && s1_load)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            older_reg    <= '0;
            newer_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s_accept)
            begin
                pos_reg   <= pos_next;
                older_reg <= newer_reg;
                newer_reg <= s_tdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s1_load)
        begin
            s1_a_reg     <= older_reg;
            s1_b_reg     <= newer_reg;
            s1_c_reg     <= s_tdata;
            s1_pos_reg   <= s1_pos_next;
            s1_grade_reg <= s1_grade_next;
            s1_count_reg <= s1_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Grading: nine constant-ratio tests on the window, then the count of
    // leading steps that pass. All three values are non-negative whenever
    // the gate opens, so the products are taken unsigned.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic                          gate;
        logic [wclc_pkg::PROD_W-1:0]   a_x, b_x, c_x;
        logic [wclc_pkg::PROD_W-1:0]   a10, b10, c10, a5, b5, fa, fb;
        logic                          up, jump, down, drop, run;
        logic [wclc_pkg::GRADE_STEPS-1:0] step_ok;

        gate = s1_grade_reg && !s1_a_reg[wclc_pkg::SAMPLE_W-1]
            && !s1_c_reg[wclc_pkg::SAMPLE_W-1] && !s1_b_reg[wclc_pkg::SAMPLE_W-1]
            && (s1_b_reg[wclc_pkg::SAMPLE_W-2:0] >= min_level_reg);
        a_x = wclc_pkg::PROD_W'(s1_a_reg[wclc_pkg::SAMPLE_W-2:0]);
        b_x = wclc_pkg::PROD_W'(s1_b_reg[wclc_pkg::SAMPLE_W-2:0]);
        c_x = wclc_pkg::PROD_W'(s1_c_reg[wclc_pkg::SAMPLE_W-2:0]);
        a10 = a_x * wclc_pkg::PROD_W'(10);
        b10 = b_x * wclc_pkg::PROD_W'(10);
        c10 = c_x * wclc_pkg::PROD_W'(10);
        a5  = a_x * wclc_pkg::PROD_W'(5);
        b5  = b_x * wclc_pkg::PROD_W'(5);

        for (int s = 1; s <= wclc_pkg::GRADE_STEPS; s++)
        begin
            fa   = a_x * wclc_pkg::PROD_W'(10 + s);
            fb   = b_x * wclc_pkg::PROD_W'(10 + s);
            up   = (b10 > fa) && (c10 > fb);
            jump = b5 > a_x * wclc_pkg::PROD_W'(5 + s);
            drop = b_x * wclc_pkg::PROD_W'(5 + s) < a5;
            fa   = a_x * wclc_pkg::PROD_W'(10 - s);
            fb   = b_x * wclc_pkg::PROD_W'(10 - s);
            down = (b10 < fa) && (c10 < fb);
            step_ok[s-1] = up || jump || down || drop;
        end

        grade_level = '0;
        run = gate;
        for (int s = 1; s <= wclc_pkg::GRADE_STEPS; s++)
        begin
            run = run && step_ok[s-1];
            if (run)
                grade_level = wclc_pkg::LEVEL_W'(s);
        end
    end

    // ------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (m_accept)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            cnt_next    = cnt_next - CNT_W'(1);
        end
        if (s1_push)
        begin
            unique case (s1_count_reg)
                wclc_pkg::RES_ONE:
                begin
                    wr_ptr_next = wr_ptr_plus1;
                    cnt_next    = cnt_next + CNT_W'(1);
                end
                wclc_pkg::RES_TWO:
                begin
                    wr_ptr_next = wr_ptr_reg + PTR_W'(2);
                    cnt_next    = cnt_next + CNT_W'(2);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_push)
        begin
            fifo_pos_reg[wr_ptr_reg] <= s1_pos_reg;
            if (s1_count_reg == wclc_pkg::RES_TWO)
            begin
                fifo_level_reg[wr_ptr_reg]   <= '0;
                fifo_last_reg[wr_ptr_reg]    <= 1'b0;
                fifo_level_reg[wr_ptr_plus1] <= '0;
                fifo_pos_reg[wr_ptr_plus1]   <= s1_pos_reg + POS_W'(1);
                fifo_last_reg[wr_ptr_plus1]  <= 1'b1;
            end
            else
            begin
                fifo_level_reg[wr_ptr_reg] <= grade_level;
                fifo_last_reg[wr_ptr_reg]  <= 1'b0;
            end
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {{PAD_W{1'b0}}, fifo_pos_reg[rd_ptr_reg], fifo_level_reg[rd_ptr_reg]};
    assign m_tlast  = fifo_last_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    // The queue never holds more words than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // The word that closes a series always carries level zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> fifo_level_reg[rd_ptr_reg] == '0)
        else $error("closing word with nonzero level");

    // The first sample of a series leaves the input stage empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && pos_reg == '0 && !is_final |=> !s1_valid_reg)
        else $error("first sample of a series produced a result");

    // The position counter stays inside the longest series.
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(pos_reg) < CMP_W'(MAX_SERIES_LEN))
        else $error("position counter out of range");
`endif

endmodule
